// File: sv/bto_pkg.sv
// ----------------------------------------------------------------------------
// bto_pkg: shared types and constants of the binomial tree option pricer
// Holds the register indexes, the sequencer states and the configuration type.
// ----------------------------------------------------------------------------
`default_nettype none

package bto_pkg;

    localparam int MAX_LEVELS_DEF = 64;
    localparam int VALUE_W        = 32;
    localparam int STEPS_W        = 7;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OPTION_KIND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIKE_PRICE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BARRIER_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_STEPS       = 3'd4;

    localparam logic KIND_CALL_DOWN_OUT = 1'b0;
    localparam logic KIND_AMERICAN_PUT  = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD,
        ST_MUL,
        ST_WR,
        ST_ALIGN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] strike;
        logic [VALUE_W-1:0] barrier;
        logic [VALUE_W-1:0] discount;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/bto_cell.sv
// ----------------------------------------------------------------------------
// bto_cell: one cell of the value row
// Holds one node value and takes its right neighbor's value, or a freshly
// computed value when it is the insertion point, on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bto_cell (
    input  wire logic                        clk,
    input  wire logic                        shift,
    input  wire logic                        sel,
    input  wire logic [bto_pkg::VALUE_W-1:0] ins,
    input  wire logic [bto_pkg::VALUE_W-1:0] right,
    output logic      [bto_pkg::VALUE_W-1:0] value
);

    logic [bto_pkg::VALUE_W-1:0] value_reg;
    logic [bto_pkg::VALUE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (shift)
        begin
            value_next = sel ? ins : right;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: sv/bto_eval.sv
// ----------------------------------------------------------------------------
// bto_eval: node evaluation unit
// Registers the discounted sum of two children and the node spot, then forms
// the terminal payoff or the continuation value with barrier or early exercise.
// ----------------------------------------------------------------------------
`default_nettype none

module bto_eval (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire bto_pkg::cfg_t               cfg,
    input  wire logic                        term,
    input  wire logic [bto_pkg::VALUE_W-1:0] a,
    input  wire logic [bto_pkg::VALUE_W-1:0] b,
    input  wire logic [bto_pkg::VALUE_W-1:0] spot,
    output logic      [bto_pkg::VALUE_W-1:0] result
);

    localparam int VW = bto_pkg::VALUE_W;
    localparam int PW = 2 * VW + 1;

    logic [VW:0]        sum;
    logic [PW-1:0]      prod_next;
    logic [PW-1:0]      prod_reg;
    logic [VW-1:0]      spot_reg;
    logic [VW-1:0]      cont;
    logic [VW-1:0]      intr;
    logic [VW-1:0]      call_pay;
    logic               above;

    always_comb
    begin
        sum       = {1'b0, a} + {1'b0, b};
        prod_next = {1'b0, (2*VW)'(sum[VW-1:0]) * (2*VW)'(cfg.discount)};
        if (sum[VW])
        begin
            prod_next = prod_next + {1'b0, cfg.discount, {VW{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            spot_reg <= spot;
        end
    end

    always_comb
    begin
        cont     = prod_reg[PW-1:VW+1];
        intr     = (cfg.strike > spot_reg) ? cfg.strike - spot_reg : '0;
        call_pay = (spot_reg > cfg.strike) ? spot_reg - cfg.strike : '0;
        above    = spot_reg > cfg.barrier;
        if (cfg.kind == bto_pkg::KIND_AMERICAN_PUT)
        begin
            if (term)
            begin
                result = intr;
            end
            else
            begin
                result = (cont > intr) ? cont : intr;
            end
        end
        else
        begin
            if (!above)
            begin
                result = '0;
            end
            else
            begin
                result = term ? call_pay : cont;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/binomial_tree_option_pricer_top.sv
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer_top: binomial tree option pricer
// Loads tree spots into a node memory and prices by backward induction.
// ----------------------------------------------------------------------------
// Spots load at one item per cycle while s_tready is high; the item marked tlast
// starts the sweep, during which no item is taken, and it is held off while a
// root value still waits for m_tready. Each node passes three states (memory
// read, multiply, write into the value row), each level above the terminal one
// passes one more state to realign the row of cells, and a last state captures
// the root value. The root value then waits in an output register while
// loading of the next tree goes on.
`default_nettype none

module binomial_tree_option_pricer_top #(
    parameter int MAX_LEVELS = bto_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [bto_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bto_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [31:0]                      s_tdata,  // spot_price[31:0]
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [31:0]                      m_tdata,  // option_price[31:0]
    output logic                                  m_tuser   // count_mismatch
);

    localparam int VW     = bto_pkg::VALUE_W;
    localparam int TREE   = MAX_LEVELS * (MAX_LEVELS + 1) / 2;
    localparam int SAT    = TREE + 1;
    localparam int AW     = (TREE > 1) ? $clog2(TREE) : 1;
    localparam int CW     = $clog2(TREE + 2);
    localparam int LW     = $clog2(MAX_LEVELS + 1);
    localparam int IW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    bto_pkg::state_t state_reg, state_next;
    bto_pkg::cfg_t   cfg;

    logic                         kind_reg;
    logic [VW-1:0]                strike_reg;
    logic [VW-1:0]                barrier_reg;
    logic [VW-1:0]                discount_reg;
    logic [bto_pkg::STEPS_W-1:0]  steps_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] j_reg, j_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] base_reg, base_next;
    logic          term_reg, term_next;
    logic          mism_reg, mism_next;

    logic          out_valid_reg;
    logic [VW-1:0] out_data_reg;
    logic          out_mism_reg;

    logic [VW-1:0] mem [TREE];
    logic [VW-1:0] rdata_reg;

    logic          accept;
    logic          load_last;
    logic [CW-1:0] count_inc;
    logic [LW-1:0] n_eff;
    logic [2*LW-1:0] tri_lo;
    logic [2*LW-1:0] tri_hi;
    logic          last_in_level;
    logic [LW-1:0] pos;

    logic          shift_en;
    logic          ins_en;
    logic          eval_en;

    logic [VW-1:0] vals [MAX_LEVELS];
    logic [VW-1:0] ins_val;

    assign cfg = '{kind: kind_reg, strike: strike_reg, barrier: barrier_reg,
                   discount: discount_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= bto_pkg::KIND_CALL_DOWN_OUT;
            strike_reg   <= '0;
            barrier_reg  <= '0;
            discount_reg <= '0;
            steps_reg    <= bto_pkg::STEPS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bto_pkg::REG_OPTION_KIND:     kind_reg     <= cfg_data[0];
                bto_pkg::REG_STRIKE_PRICE:    strike_reg   <= cfg_data[VW-1:0];
                bto_pkg::REG_BARRIER_LEVEL:   barrier_reg  <= cfg_data[VW-1:0];
                bto_pkg::REG_DISCOUNT_FACTOR: discount_reg <= cfg_data[VW-1:0];
                bto_pkg::REG_NUM_STEPS:
                    steps_reg <= cfg_data[bto_pkg::STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (steps_reg == '0)
        begin
            n_eff = LW'(1);
        end
        else if (int'(steps_reg) > MAX_LEVELS)
        begin
            n_eff = LW'(MAX_LEVELS);
        end
        else
        begin
            n_eff = LW'(steps_reg);
        end
        tri_lo = ({{LW{1'b0}}, n_eff} * {{LW{1'b0}}, n_eff - LW'(1)}) >> 1;
        tri_hi = ({{LW{1'b0}}, n_eff} * {{LW{1'b0}}, n_eff + LW'(1)}) >> 1;
    end

    assign accept    = s_tvalid && s_tready;
    assign load_last = accept && s_tlast;
    assign count_inc = (int'(count_reg) < SAT) ? count_reg + CW'(1) : count_reg;
    assign last_in_level = (j_reg == cnt_reg - LW'(1));
    assign pos = term_reg ? cnt_reg - LW'(1) : cnt_reg;

    always_ff @(posedge clk)
    begin
        if (accept && (int'(count_reg) < TREE))
        begin
            mem[count_reg[AW-1:0]] <= s_tdata[VW-1:0];
        end
        rdata_reg <= mem[addr_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bto_pkg::ST_LOAD:  if (load_last) state_next = bto_pkg::ST_RD;
            bto_pkg::ST_RD:    state_next = bto_pkg::ST_MUL;
            bto_pkg::ST_MUL:   state_next = bto_pkg::ST_WR;
            bto_pkg::ST_WR:
            begin
                if (!last_in_level)
                begin
                    state_next = bto_pkg::ST_RD;
                end
                else if (!term_reg)
                begin
                    state_next = bto_pkg::ST_ALIGN;
                end
                else
                begin
                    state_next = (cnt_reg == LW'(1)) ? bto_pkg::ST_DONE : bto_pkg::ST_RD;
                end
            end
            bto_pkg::ST_ALIGN:
                state_next = (cnt_reg == LW'(1)) ? bto_pkg::ST_DONE : bto_pkg::ST_RD;
            bto_pkg::ST_DONE:  state_next = bto_pkg::ST_LOAD;
            default:           state_next = bto_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        shift_en = 1'b0;
        ins_en   = 1'b0;
        eval_en  = 1'b0;
        unique case (state_reg)
            bto_pkg::ST_LOAD:  s_tready = !s_tlast || !out_valid_reg;
            bto_pkg::ST_MUL:   eval_en  = 1'b1;
            bto_pkg::ST_WR:
            begin
                shift_en = 1'b1;
                ins_en   = 1'b1;
            end
            bto_pkg::ST_ALIGN: shift_en = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        addr_next  = addr_reg;
        base_next  = base_reg;
        term_next  = term_reg;
        mism_next  = mism_reg;
        if (accept)
        begin
            count_next = count_inc;
            if (s_tlast)
            begin
                count_next = '0;
                cnt_next   = n_eff;
                j_next     = '0;
                addr_next  = AW'(tri_lo);
                base_next  = AW'(tri_lo);
                term_next  = 1'b1;
                mism_next  = (CW'(tri_hi) != count_inc);
            end
        end
        else if (state_reg == bto_pkg::ST_WR && !last_in_level)
        begin
            j_next    = j_reg + LW'(1);
            addr_next = addr_reg + AW'(1);
        end
        else if ((state_reg == bto_pkg::ST_WR && term_reg) || state_reg == bto_pkg::ST_ALIGN)
        begin
            cnt_next  = cnt_reg - LW'(1);
            j_next    = '0;
            base_next = base_reg - AW'(cnt_reg - LW'(1));
            addr_next = base_reg - AW'(cnt_reg - LW'(1));
            term_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bto_pkg::ST_LOAD;
            count_reg     <= '0;
            cnt_reg       <= LW'(1);
            j_reg         <= '0;
            term_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cnt_reg   <= cnt_next;
            j_reg     <= j_next;
            term_reg  <= term_next;
            if (state_reg == bto_pkg::ST_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        base_reg <= base_next;
        mism_reg <= mism_next;
        if (state_reg == bto_pkg::ST_DONE)
        begin
            out_data_reg <= vals[0];
            out_mism_reg <= mism_reg;
        end
    end

    bto_eval u_eval (
        .clk    (clk),
        .en     (eval_en),
        .cfg    (cfg),
        .term   (term_reg),
        .a      (vals[0]),
        .b      (vals[(MAX_LEVELS > 1) ? 1 : 0]),
        .spot   (rdata_reg),
        .result (ins_val)
    );

    for (genvar k = 0; k < MAX_LEVELS; k++)
    begin : g_row
        logic [VW-1:0] right_val;
        if (k < MAX_LEVELS - 1)
        begin : g_mid
            assign right_val = vals[k + 1];
        end
        else
        begin : g_end
            assign right_val = ins_val;
        end
        bto_cell u_cell (
            .clk   (clk),
            .shift (shift_en),
            .sel   (ins_en && (pos[IW-1:0] == IW'(k))),
            .ins   (ins_val),
            .right (right_val),
            .value (vals[k])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_mism_reg;

    a_last_starts_sweep : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == bto_pkg::ST_RD))
        else $error("sweep did not start after the last item");

    a_no_result_in_sweep : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bto_pkg::ST_LOAD && state_reg != bto_pkg::ST_DONE) |-> !out_valid_reg)
        else $error("result pending while a sweep runs");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (int'(count_reg) <= SAT))
        else $error("load count beyond saturation");

    a_level_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bto_pkg::ST_WR) |-> (j_reg < cnt_reg && int'(pos) < MAX_LEVELS))
        else $error("node index outside current level");

endmodule

`default_nettype wire

// File: verif/binomial_tree_option_pricer_top_test.sv
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer_top_test: regression for the option pricer
// Loads spot trees over the input stream under several register settings and
// checks each root value and count flag against a predictor kept in the bench.
// ----------------------------------------------------------------------------
module binomial_tree_option_pricer_top_test;

    localparam int LEVELS      = bto_pkg::MAX_LEVELS_DEF;
    localparam int NODES       = LEVELS * (LEVELS + 1) / 2;
    localparam int CYCLE_CAP   = 1000000;
    localparam int SHOW_ERRS   = 10;
    localparam int HOLD_CYCLES = 400;

    localparam logic [bto_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [bto_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [31:0] price;
        logic        mismatch;
    } root_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bto_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bto_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [31:0]                    s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [31:0]                    m_tdata;
    logic                           m_tuser;

    binomial_tree_option_pricer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    logic        kind_q;
    logic [31:0] strike_q;
    logic [31:0] barrier_q;
    logic [31:0] disc_q;
    logic [6:0]  steps_q;
    logic [31:0] node_mem [0:NODES-1];
    logic [31:0] value_row [0:LEVELS-1];
    int          nodes_loaded;

    root_result_t pending_roots[$];
    int  err_count;
    int  roots_checked;
    int  items_sent;
    int  trees_sent;
    int  snd_idle_pct;
    int  rcv_stall_pct;
    int  hold_reqs;
    int  hold_seen;
    int  hold_left;
    int  cycle_count = 0;
    logic rdy_seen;
    logic mv_seen;
    logic mr_seen;
    logic [31:0] md_seen;
    logic mu_seen;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [31:0] shortfall(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    function automatic logic [31:0] discounted_mean(input logic [31:0] a,
                                                    input logic [31:0] b,
                                                    input logic [31:0] d);
        logic [64:0] p;
        p = 65'(a) + 65'(b);
        p = p * 65'(d);
        return p[64:33];
    endfunction

    function automatic logic [31:0] price_tree(input int n);
        int base;
        logic [31:0] s;
        logic [31:0] cont;
        logic [31:0] intr;
        base = n * (n - 1) / 2;
        for (int j = 0; j < n; j++)
        begin
            s = node_mem[base + j];
            if (kind_q == bto_pkg::KIND_CALL_DOWN_OUT)
                value_row[j] = (s > barrier_q) ? shortfall(s, strike_q) : 32'd0;
            else
                value_row[j] = shortfall(strike_q, s);
        end
        for (int lv = n - 1; lv >= 1; lv--)
        begin
            base = lv * (lv - 1) / 2;
            for (int j = 0; j < lv; j++)
            begin
                s = node_mem[base + j];
                cont = discounted_mean(value_row[j], value_row[j + 1], disc_q);
                if (kind_q == bto_pkg::KIND_CALL_DOWN_OUT)
                begin
                    value_row[j] = (s > barrier_q) ? cont : 32'd0;
                end
                else
                begin
                    intr = shortfall(strike_q, s);
                    value_row[j] = (cont > intr) ? cont : intr;
                end
            end
        end
        return value_row[0];
    endfunction

    task automatic load_node(input logic [31:0] spot, input logic last);
        int n;
        root_result_t r;
        if (nodes_loaded < NODES)
            node_mem[nodes_loaded] = spot;
        if (nodes_loaded < NODES + 1)
            nodes_loaded++;
        if (last)
        begin
            n = (steps_q == 0) ? 1 : (steps_q > LEVELS) ? LEVELS : int'(steps_q);
            r.price = price_tree(n);
            r.mismatch = (nodes_loaded != n * (n + 1) / 2);
            pending_roots.push_back(r);
            nodes_loaded = 0;
        end
    endtask

    task automatic send_item(input logic [31:0] spot, input logic last);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= spot;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!rdy_seen);
        load_node(spot, last);
        items_sent++;
        if (last)
            trees_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bto_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            bto_pkg::REG_OPTION_KIND:     kind_q = data[0];
            bto_pkg::REG_STRIKE_PRICE:    strike_q = data;
            bto_pkg::REG_BARRIER_LEVEL:   barrier_q = data;
            bto_pkg::REG_DISCOUNT_FACTOR: disc_q = data;
            bto_pkg::REG_NUM_STEPS:       steps_q = data[6:0];
            default: ;
        endcase
    endtask

    task automatic set_pricing(input logic kind, input logic [31:0] strike,
                               input logic [31:0] barrier, input logic [31:0] disc,
                               input logic [6:0] steps);
        drain();
        write_reg(bto_pkg::REG_OPTION_KIND, {31'd0, kind});
        write_reg(bto_pkg::REG_STRIKE_PRICE, strike);
        write_reg(bto_pkg::REG_BARRIER_LEVEL, barrier);
        write_reg(bto_pkg::REG_DISCOUNT_FACTOR, disc);
        write_reg(bto_pkg::REG_NUM_STEPS, {25'd0, steps});
    endtask

    function automatic logic [31:0] pick_spot();
        case ($urandom_range(4))
            0: return $urandom();
            1: return strike_q + $urandom_range(32'h0004_0000) - 32'h0002_0000;
            2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
            3: return barrier_q + $urandom_range(4) - 2;
            default: return strike_q ^ (32'd1 << $urandom_range(31));
        endcase
    endfunction

    task automatic send_tree(input int count);
        for (int i = 0; i < count; i++)
            send_item(pick_spot(), i == count - 1);
    endtask

    task automatic test_deep_tree();
        set_pricing(bto_pkg::KIND_AMERICAN_PUT, 32'h0064_0000, 32'd0, 32'hFFF0_0000, 7'd32);
        send_tree(32 * 33 / 2);
        set_pricing(bto_pkg::KIND_CALL_DOWN_OUT, 32'h0064_0000, 32'h0050_0000,
                    32'hFFFF_FFFF, 7'd20);
        send_tree(20 * 21 / 2);
    endtask

    task automatic test_directed();
        set_pricing(bto_pkg::KIND_CALL_DOWN_OUT, 32'd0, 32'd0, 32'd0, 7'd1);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'd0, 1'b1);
        set_pricing(bto_pkg::KIND_CALL_DOWN_OUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 7'd0);
        send_item(32'hFFFF_FFFF, 1'b1);
        set_pricing(bto_pkg::KIND_AMERICAN_PUT, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 7'd2);
        send_item(32'd0, 1'b0);
        send_item(32'd0, 1'b0);
        send_item(32'd0, 1'b1);
        send_item(32'h1234_5678, 1'b0);
        send_item(32'd0, 1'b1);
        set_pricing(bto_pkg::KIND_CALL_DOWN_OUT, 32'h0001_0000, 32'h0080_0000,
                    32'h8000_0000, 7'd3);
        send_item(32'h0080_0000, 1'b0);
        send_item(32'h0080_0001, 1'b0);
        send_item(32'h0080_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0080_0001, 1'b0);
        send_item(32'h0080_0000, 1'b1);
        set_pricing(bto_pkg::KIND_AMERICAN_PUT, 32'h0100_0000, 32'd0, 32'd0, 7'd4);
        send_tree(10);
        drain();
        write_reg(bto_pkg::REG_STRIKE_PRICE, 32'h00C0_0000);
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_LO, 32'd0);
        send_item(32'h0010_0000, 1'b1);
    endtask

    task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int budget);
        int stop_at;
        int levels;
        int count;
        snd_idle_pct = snd_pct;
        rcv_stall_pct = rcv_pct;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            levels = $urandom_range(6, 1);
            set_pricing(1'($urandom_range(1)), $urandom(), $urandom(),
                        ($urandom_range(3) == 0) ? $urandom() : 32'hF000_0000 | $urandom(),
                        7'(levels));
            if ($urandom_range(1))
                write_reg(bto_pkg::REG_BARRIER_LEVEL, strike_q - $urandom_range(32'h0040_0000));
            for (int t = 0; t < 6; t++)
            begin
                count = levels * (levels + 1) / 2;
                case ($urandom_range(9))
                    0: count = count + $urandom_range(3, 1);
                    1: count = (count > 1) ? count - 1 : count;
                    default: ;
                endcase
                send_tree(count);
            end
        end
    endtask

    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        set_pricing(bto_pkg::KIND_AMERICAN_PUT, 32'h0040_0000, 32'd0, 32'hFF00_0000, 7'd2);
        hold_reqs++;
        for (int t = 0; t < 12; t++)
            send_tree(3);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        kind_q = bto_pkg::KIND_CALL_DOWN_OUT;
        strike_q = '0;
        barrier_q = '0;
        disc_q = '0;
        steps_q = 7'd1;
        nodes_loaded = 0;
        err_count = 0;
        roots_checked = 0;
        items_sent = 0;
        trees_sent = 0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_reqs = 0;
        for (int i = 0; i < NODES; i++)
            node_mem[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_deep_tree();
        test_directed();
        test_random_phase(0, 0, 90);
        test_random_phase(48, 0, 90);
        test_random_phase(0, 48, 90);
        test_random_phase(37, 37, 90);
        test_backpressure();
        drain();
        repeat (200) @(posedge clk);
        $display("Covered %0d items in %0d trees, %0d root values checked,", items_sent,
                 trees_sent, roots_checked);
        $display("both option kinds, deep and small trees, short and long loads, and stalls.");
        if (err_count == 0 && pending_roots.size() == 0)
            $display("binomial_tree_option_pricer_top regression: pass");
        else
            $display("binomial_tree_option_pricer_top regression: fail");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_reqs != hold_seen)
        begin
            m_tready  <= 1'b0;
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(negedge clk)
    begin
        rdy_seen = s_tready;
        mv_seen  = m_tvalid;
        mr_seen  = m_tready;
        md_seen  = m_tdata;
        mu_seen  = m_tuser;
    end

    always @(posedge clk)
    begin
        root_result_t want;
        if (rst_n && mv_seen && mr_seen)
        begin
            roots_checked++;
            if (pending_roots.size() == 0)
            begin
                err_count++;
                if (err_count <= SHOW_ERRS)
                    $display("Unexpected root value %h, flag %b.", md_seen, mu_seen);
            end
            else
            begin
                want = pending_roots.pop_front();
                if (want.price !== md_seen || want.mismatch !== mu_seen)
                begin
                    err_count++;
                    if (err_count <= SHOW_ERRS)
                        $display("Root mismatch: expected %h flag %b, got %h flag %b.",
                                 want.price, want.mismatch, md_seen, mu_seen);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Run stopped after %0d cycles without finishing.", cycle_count);
            $display("binomial_tree_option_pricer_top regression: fail");
            $finish;
        end
    end

endmodule

// File: binomial_tree_option_pricer_top.f
sv/bto_pkg.sv
sv/bto_cell.sv
sv/bto_eval.sv
sv/binomial_tree_option_pricer_top.sv
verif/binomial_tree_option_pricer_top_test.sv
